// ----- hdl/blpw_pkg.sv -----
// Shared types, widths and constants for the Bresenham line pixel writer.
// No dependencies; every other file imports this package.
package blpw_pkg;

  localparam int COORD_BITS    = 16;
  localparam int SPAN_BITS     = COORD_BITS + 1;
  localparam int ERR_BITS      = COORD_BITS + 2;
  localparam int HEIGHT_BITS   = 16;
  localparam int DIM_BITS      = 13;
  localparam int STRIDE_BITS   = 15;
  localparam int BPP_BITS      = 6;
  localparam int ADDR_BITS     = 26;
  localparam int BYTE_BITS     = 8;
  localparam int COLOUR_BITS   = 3 * BYTE_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int EXT_BITS      = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int PRODY_BITS    = DIM_BITS + STRIDE_BITS;
  localparam int PRODX_BITS    = DIM_BITS + BPP_BITS;
  localparam int BYTE_SHIFT    = 3;

  localparam logic [DIM_BITS-1:0]    RST_FRAME_WIDTH  = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0]    RST_FRAME_HEIGHT = DIM_BITS'(768);
  localparam logic [STRIDE_BITS-1:0] RST_LINE_STRIDE  = STRIDE_BITS'(4096);
  localparam logic [BPP_BITS-1:0]    RST_BPP          = BPP_BITS'(32);

  localparam logic [COLOUR_BITS-1:0] COLOUR_RED   = 24'hFF0000;
  localparam logic [COLOUR_BITS-1:0] COLOUR_GREEN = 24'h00FF00;
  localparam logic [COLOUR_BITS-1:0] COLOUR_BLUE  = 24'h0000FF;
  localparam logic [COLOUR_BITS-1:0] COLOUR_WHITE = 24'hFFFFFF;
  localparam logic [COLOUR_BITS-1:0] COLOUR_BLACK = 24'h000000;
  localparam int RED_SHIFT   = 2 * BYTE_BITS;
  localparam int GREEN_SHIFT = BYTE_BITS;

  localparam logic ORDER_BGR = 1'b0;
  localparam logic ORDER_RGB = 1'b1;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_LINE_STRIDE  = 3'd2,
    CFG_BPP          = 3'd3,
    CFG_BYTE_ORDER   = 3'd4,
    CFG_DARK_LEVEL   = 3'd5
  } cfg_idx_t;

  // settings the back end needs
  typedef struct packed {
    logic [DIM_BITS-1:0]    frame_width;
    logic [DIM_BITS-1:0]    frame_height;
    logic [STRIDE_BITS-1:0] line_stride;
    logic [BPP_BITS-1:0]    bits_per_pixel;
    logic                   byte_order;
  } cfg_t;

  // one pixel request from front to back
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
    logic                         on_line;
    logic                         white;
  } pix_req_t;

endpackage

// ----- hdl/blpw_if.sv -----
// Valid/ready channel interfaces: line requests, pixel writes, settings.
// Depends on blpw_pkg.
interface blpw_in_if import blpw_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic signed [HEIGHT_BITS-1:0] start_height;
  logic signed [HEIGHT_BITS-1:0] end_height;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y,
                  start_height, end_height, input ready);
  modport sink (input valid, req_type, start_x, start_y, end_x, end_y,
                start_height, end_height, output ready);
endinterface

interface blpw_out_if import blpw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 pixel_valid;
  logic [ADDR_BITS-1:0] byte_address;
  logic [BYTE_BITS-1:0] byte_first;
  logic [BYTE_BITS-1:0] byte_second;
  logic [BYTE_BITS-1:0] byte_third;
  logic                 last_pixel;

  modport source (output valid, pixel_valid, byte_address, byte_first, byte_second,
                  byte_third, last_pixel, input ready);
  modport sink (input valid, pixel_valid, byte_address, byte_first, byte_second,
                byte_third, last_pixel, output ready);
endinterface

interface blpw_cfg_if import blpw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/blpw_front.sv -----
// Front end: accepts requests, runs the Bresenham stepper, pushes pixel requests.
// Depends on blpw_pkg and blpw_in_if.
module blpw_front import blpw_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  blpw_in_if.sink                       in_bus,
  input  logic signed [HEIGHT_BITS-1:0] dark_level,
  output logic                          push_valid,
  input  logic                          push_ready,
  output pix_req_t                      push_item
);

  logic signed [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic [SPAN_BITS-1:0]         span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  logic                         dir_x_neg_r, dir_x_neg_nxt, dir_y_neg_r, dir_y_neg_nxt;
  logic [ERR_BITS-1:0]          err_r, err_nxt;
  logic                         white_r, white_nxt;
  logic                         active_r, active_nxt;

  logic                         acc;
  logic signed [SPAN_BITS-1:0]  dx, dy;
  logic [SPAN_BITS-1:0]         sx0, sy0;
  logic signed [ERR_BITS:0]     e_w, sx_w, sy_w, e_new;
  logic                         go_x, go_y;
  logic signed [COORD_BITS-1:0] nx, ny;

  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid;
  assign acc          = in_bus.valid && push_ready;

  // start: spans and initial error term
  assign dx  = SPAN_BITS'(in_bus.end_x) - SPAN_BITS'(in_bus.start_x);
  assign dy  = SPAN_BITS'(in_bus.end_y) - SPAN_BITS'(in_bus.start_y);
  assign sx0 = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
  assign sy0 = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);

  // step: error compared against -span_x and span_y
  assign e_w   = (ERR_BITS + 1)'($signed(err_r));
  assign sx_w  = $signed({2'b00, span_x_r});
  assign sy_w  = $signed({2'b00, span_y_r});
  assign go_x  = e_w > -sx_w;
  assign go_y  = e_w < sy_w;
  assign e_new = e_w - (go_x ? sy_w : '0) + (go_y ? sx_w : '0);
  assign nx    = go_x ? (dir_x_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1))
                      : cur_x_r;
  assign ny    = go_y ? (dir_y_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1))
                      : cur_y_r;

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    span_x_nxt    = span_x_r;
    span_y_nxt    = span_y_r;
    dir_x_neg_nxt = dir_x_neg_r;
    dir_y_neg_nxt = dir_y_neg_r;
    err_nxt       = err_r;
    white_nxt     = white_r;
    active_nxt    = active_r;
    push_item     = '{x: cur_x_r, y: cur_y_r, last: 1'b1, on_line: 1'b0, white: white_r};
    case (req_type_t'(in_bus.req_type))
      REQ_START: begin
        cur_x_nxt     = in_bus.start_x;
        cur_y_nxt     = in_bus.start_y;
        tgt_x_nxt     = in_bus.end_x;
        tgt_y_nxt     = in_bus.end_y;
        span_x_nxt    = sx0;
        span_y_nxt    = sy0;
        dir_x_neg_nxt = !(in_bus.start_x < in_bus.end_x);
        dir_y_neg_nxt = !(in_bus.start_y < in_bus.end_y);
        err_nxt       = (sx0 > sy0) ? ERR_BITS'(sx0 >> 1) : -ERR_BITS'(sy0 >> 1);
        white_nxt     = !(in_bus.start_height == dark_level &&
                          in_bus.end_height == dark_level);
        push_item.x       = in_bus.start_x;
        push_item.y       = in_bus.start_y;
        push_item.last    = in_bus.start_x == in_bus.end_x && in_bus.start_y == in_bus.end_y;
        push_item.on_line = 1'b1;
        push_item.white   = white_nxt;
        active_nxt        = !push_item.last;
      end
      REQ_STEP: begin
        if (active_r) begin
          cur_x_nxt         = nx;
          cur_y_nxt         = ny;
          err_nxt           = e_new[ERR_BITS-1:0];
          push_item.x       = nx;
          push_item.y       = ny;
          push_item.last    = nx == tgt_x_r && ny == tgt_y_r;
          push_item.on_line = 1'b1;
          active_nxt        = !push_item.last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      span_x_r    <= '0;
      span_y_r    <= '0;
      dir_x_neg_r <= 1'b0;
      dir_y_neg_r <= 1'b0;
      err_r       <= '0;
      white_r     <= 1'b0;
      active_r    <= 1'b0;
    end else if (acc) begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      tgt_x_r     <= tgt_x_nxt;
      tgt_y_r     <= tgt_y_nxt;
      span_x_r    <= span_x_nxt;
      span_y_r    <= span_y_nxt;
      dir_x_neg_r <= dir_x_neg_nxt;
      dir_y_neg_r <= dir_y_neg_nxt;
      err_r       <= err_nxt;
      white_r     <= white_nxt;
      active_r    <= active_nxt;
    end
  end

  a_single_point_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_bus.req_type == REQ_START && in_bus.start_x == in_bus.end_x &&
     in_bus.start_y == in_bus.end_y) |=> !active_r)
    else $error("single-point line left active");

  a_active_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(acc) |-> $stable(active_r) && $stable(cur_x_r) && $stable(cur_y_r))
    else $error("stepper state changed without an accepted beat");

endmodule

// ----- hdl/blpw_queue.sv -----
// Short FIFO of pixel requests between the stepper and the address back end.
// Depends on blpw_pkg.
module blpw_queue import blpw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  pix_req_t push_item,
  output logic     pop_valid,
  input  logic     pop_ready,
  output pix_req_t pop_item
);

  pix_req_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 push_fire, pop_fire;

  assign push_ready = count_r != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_fire && !pop_fire) |=> count_r == $past(count_r) + QCNT_BITS'(1))
    else $error("queue count lost a push");

endmodule

// ----- hdl/blpw_back.sv -----
// Back end: clips a pixel, forms its byte address and colour bytes, holds the result.
// Depends on blpw_pkg and blpw_out_if.
module blpw_back import blpw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  pix_req_t  pop_item,
  blpw_out_if.source out_bus
);

  logic signed [EXT_BITS-1:0] x_ext, y_ext;
  logic                       in_frame;
  logic [DIM_BITS-1:0]        x_pix, y_pix;
  logic                       s1_ready, s2_ready;

  // stage 1: clip and multiply
  logic                   s1_valid_r;
  logic                   s1_in_r;
  logic                   s1_last_r;
  logic                   s1_white_r;
  logic [PRODY_BITS-1:0]  s1_prod_y_r;
  logic [PRODX_BITS-1:0]  s1_prod_x_r;

  // stage 2: result register
  logic                   out_valid_r;
  logic                   out_pixel_valid_r;
  logic [ADDR_BITS-1:0]   out_addr_r;
  logic [BYTE_BITS-1:0]   out_first_r, out_second_r, out_third_r;
  logic                   out_last_r;

  logic [COLOUR_BITS-1:0] colour;
  logic [BYTE_BITS-1:0]   red_b, green_b, blue_b;
  logic [ADDR_BITS-1:0]   addr_nxt;

  assign x_ext    = EXT_BITS'(pop_item.x);
  assign y_ext    = EXT_BITS'(pop_item.y);
  assign in_frame = pop_item.on_line && !x_ext[EXT_BITS-1] && !y_ext[EXT_BITS-1] &&
                    $unsigned(x_ext) < EXT_BITS'(cfg.frame_width) &&
                    $unsigned(y_ext) < EXT_BITS'(cfg.frame_height);
  assign x_pix    = x_ext[DIM_BITS-1:0];
  assign y_pix    = y_ext[DIM_BITS-1:0];

  assign s2_ready  = !out_valid_r || out_bus.ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign pop_ready = s1_ready;

  assign colour   = s1_white_r ? COLOUR_WHITE : COLOUR_BLACK;
  assign red_b    = BYTE_BITS'((colour & COLOUR_RED) >> RED_SHIFT);
  assign green_b  = BYTE_BITS'((colour & COLOUR_GREEN) >> GREEN_SHIFT);
  assign blue_b   = BYTE_BITS'(colour & COLOUR_BLUE);
  // x*bpp/8 is a shift; the sum wraps to the address width
  assign addr_nxt = ADDR_BITS'(s1_prod_y_r) + ADDR_BITS'(s1_prod_x_r >> BYTE_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= pop_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pop_valid) begin
      s1_in_r     <= in_frame;
      s1_last_r   <= pop_item.last;
      s1_white_r  <= pop_item.white;
      s1_prod_y_r <= PRODY_BITS'(y_pix) * PRODY_BITS'(cfg.line_stride);
      s1_prod_x_r <= PRODX_BITS'(x_pix) * PRODX_BITS'(cfg.bits_per_pixel);
    end
    if (s2_ready && s1_valid_r) begin
      out_pixel_valid_r <= s1_in_r;
      out_last_r        <= s1_last_r;
      out_addr_r        <= s1_in_r ? addr_nxt : '0;
      out_second_r      <= s1_in_r ? green_b : '0;
      if (!s1_in_r) begin
        out_first_r <= '0;
        out_third_r <= '0;
      end else if (cfg.byte_order == ORDER_RGB) begin
        out_first_r <= red_b;
        out_third_r <= blue_b;
      end else begin
        out_first_r <= blue_b;
        out_third_r <= red_b;
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.pixel_valid  = out_pixel_valid_r;
  assign out_bus.byte_address = out_addr_r;
  assign out_bus.byte_first   = out_first_r;
  assign out_bus.byte_second  = out_second_r;
  assign out_bus.byte_third   = out_third_r;
  assign out_bus.last_pixel   = out_last_r;

endmodule

// ----- hdl/bresenham_line_pixel_writer.sv -----
// Bresenham line pixel writer, top level: settings registers, stepper, queue, back end.
// Path: an accepted request is written into the queue, then clipped and multiplied into the
// stage 1 register, then its address sum goes into the result register. Throughput: one
// request per cycle while the queue has room, as the stepper updates on every accepted
// request; the 2-entry queue and 2-stage back end stall independently. Reset (rst_n low,
// synchronous): settings return to their defaults, no line active, queue and pipeline empty.
module bresenham_line_pixel_writer import blpw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  blpw_cfg_if.sink    cfg_bus,
  blpw_in_if.sink     in_bus,
  blpw_out_if.source  out_bus
);

  logic [DIM_BITS-1:0]           frame_width_r, frame_height_r;
  logic [STRIDE_BITS-1:0]        line_stride_r;
  logic [BPP_BITS-1:0]           bpp_r;
  logic                          byte_order_r;
  logic signed [HEIGHT_BITS-1:0] dark_level_r;
  cfg_t                          cfg;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  pix_req_t push_item, pop_item;

  // settings writes are taken every cycle
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      line_stride_r  <= RST_LINE_STRIDE;
      bpp_r          <= RST_BPP;
      byte_order_r   <= ORDER_BGR;
      dark_level_r   <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_idx_t'(cfg_bus.index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_bus.data[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_bus.data[DIM_BITS-1:0];
        CFG_LINE_STRIDE:  line_stride_r  <= cfg_bus.data[STRIDE_BITS-1:0];
        CFG_BPP:          bpp_r          <= cfg_bus.data[BPP_BITS-1:0];
        CFG_BYTE_ORDER:   byte_order_r   <= cfg_bus.data[0];
        CFG_DARK_LEVEL:   dark_level_r   <= $signed(cfg_bus.data[HEIGHT_BITS-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = '{frame_width:    frame_width_r,
                 frame_height:   frame_height_r,
                 line_stride:    line_stride_r,
                 bits_per_pixel: bpp_r,
                 byte_order:     byte_order_r};

  blpw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .dark_level (dark_level_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  blpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  blpw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_bus   (out_bus)
  );

endmodule

// ----- tb/bresenham_line_pixel_writer_tb.sv -----
// Self-checking testbench for bresenham_line_pixel_writer: line requests in, pixel writes out.
// Depends on blpw_pkg and the channel interfaces in blpw_if; predicts every pixel beat and
// checks it field by field while the settings, idling and back-pressure change by phase.
module bresenham_line_pixel_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import blpw_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 185;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    req_type_t                     kind;
    logic signed [COORD_BITS-1:0]  sx;
    logic signed [COORD_BITS-1:0]  sy;
    logic signed [COORD_BITS-1:0]  ex;
    logic signed [COORD_BITS-1:0]  ey;
    logic signed [HEIGHT_BITS-1:0] sh;
    logic signed [HEIGHT_BITS-1:0] eh;
  } line_req_t;

  typedef struct packed {
    logic                 on_frame;
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_BITS-1:0] b0;
    logic [BYTE_BITS-1:0] b1;
    logic [BYTE_BITS-1:0] b2;
    logic                 is_last;
  } pixel_wr_t;

  logic clk;
  logic rst_n;

  blpw_cfg_if cfg_bus ();
  blpw_in_if  in_bus ();
  blpw_out_if out_bus ();

  bresenham_line_pixel_writer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_bus(cfg_bus),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  line_req_t req_queue[$];
  pixel_wr_t expected_pixels[$];
  line_req_t offered;
  bit        in_beat;
  int        fail_count;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_req;
  int        hold_left;

  // settings as the block should hold them
  logic [DIM_BITS-1:0]    cfg_w;
  logic [DIM_BITS-1:0]    cfg_h;
  logic [STRIDE_BITS-1:0] cfg_stride;
  logic [BPP_BITS-1:0]    cfg_bpp;
  logic                   cfg_order;
  logic [HEIGHT_BITS-1:0] cfg_dark;

  // line walker state
  int pos_x, pos_y, goal_x, goal_y;
  int run_x, run_y;
  bit neg_x, neg_y;
  int err_acc;
  bit white;
  bit drawing;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic pixel_wr_t shade_pixel(bit done);
    pixel_wr_t              p;
    logic [COLOUR_BITS-1:0] colour;
    logic [BYTE_BITS-1:0]   red, grn, blu;
    longint                 addr;
    colour = white ? COLOUR_WHITE : COLOUR_BLACK;
    red = colour[RED_SHIFT +: BYTE_BITS];
    grn = colour[GREEN_SHIFT +: BYTE_BITS];
    blu = colour[0 +: BYTE_BITS];
    p = '0;
    p.is_last = done;
    if (pos_x >= 0 && pos_y >= 0 && pos_x < int'(cfg_w) && pos_y < int'(cfg_h)) begin
      addr = longint'(pos_y) * longint'(cfg_stride) + longint'(pos_x) * longint'(cfg_bpp) / 8;
      p.on_frame = 1'b1;
      p.addr = addr[ADDR_BITS-1:0];
      p.b0 = (cfg_order == ORDER_RGB) ? red : blu;
      p.b1 = grn;
      p.b2 = (cfg_order == ORDER_RGB) ? blu : red;
    end
    return p;
  endfunction

  function automatic pixel_wr_t rasterize(line_req_t r);
    pixel_wr_t p;
    int        e2;
    bit        done;
    if (r.kind == REQ_START) begin
      pos_x = r.sx;
      pos_y = r.sy;
      goal_x = r.ex;
      goal_y = r.ey;
      run_x = (goal_x >= pos_x) ? goal_x - pos_x : pos_x - goal_x;
      run_y = (goal_y >= pos_y) ? goal_y - pos_y : pos_y - goal_y;
      neg_x = !(pos_x < goal_x);
      neg_y = !(pos_y < goal_y);
      // truncates toward zero, as the hardware's halving shift of the span does
      err_acc = (run_x > run_y ? run_x : -run_y) / 2;
      white = !(r.sh == cfg_dark && r.eh == cfg_dark);
      done = (pos_x == goal_x && pos_y == goal_y);
      drawing = !done;
      return shade_pixel(done);
    end
    if (!drawing) begin
      p = '0;
      p.is_last = 1'b1;
      return p;
    end
    e2 = err_acc;
    if (e2 > -run_x) begin
      err_acc -= run_y;
      pos_x += neg_x ? -1 : 1;
    end
    if (e2 < run_y) begin
      err_acc += run_x;
      pos_y += neg_y ? -1 : 1;
    end
    done = (pos_x == goal_x && pos_y == goal_y);
    if (done) drawing = 1'b0;
    return shade_pixel(done);
  endfunction

  function automatic string describe(pixel_wr_t p);
    return $sformatf("valid=%0d addr=%h bytes=%h,%h,%h last=%0d",
                     p.on_frame, p.addr, p.b0, p.b1, p.b2, p.is_last);
  endfunction

  function automatic void push_start(int x0, int y0, int x1, int y1, int h0, int h1);
    line_req_t r;
    r.kind = REQ_START;
    r.sx = x0;
    r.sy = y0;
    r.ex = x1;
    r.ey = y1;
    r.sh = h0;
    r.eh = h1;
    req_queue.push_back(r);
  endfunction

  // coordinate fields of a step are don't-care, so they carry noise
  function automatic void push_steps(int n);
    line_req_t r;
    for (int i = 0; i < n; i++) begin
      r.kind = REQ_STEP;
      r.sx = $urandom;
      r.sy = $urandom;
      r.ex = $urandom;
      r.ey = $urandom;
      r.sh = $urandom;
      r.eh = $urandom;
      req_queue.push_back(r);
    end
  endfunction

  // half near the origin, half anywhere across the frame, with a margin past the edges
  function automatic int pick_coord(int dim);
    if ($urandom_range(1) == 0) return int'($urandom_range(0, 40)) - 8;
    return int'($urandom_range(0, dim + 16)) - 8;
  endfunction

  function automatic int make_line();
    int x0, y0, x1, y1, dx, dy, needed, nsteps, roll, h0, h1, n;
    n = 0;
    if ($urandom_range(19) == 0) begin
      nsteps = $urandom_range(1, 2);
      push_steps(nsteps);
      n += nsteps;
    end
    roll = $urandom_range(19);
    if (roll < 2) begin
      // full-range endpoints; cut short by the next start
      x0 = $urandom;
      y0 = $urandom;
      x1 = $urandom;
      y1 = $urandom;
      nsteps = $urandom_range(0, 3);
    end else begin
      x0 = pick_coord(cfg_w);
      y0 = pick_coord(cfg_h);
      if (roll == 2) begin
        x1 = x0;
        y1 = y0;
      end else begin
        x1 = x0 + int'($urandom_range(0, 40)) - 20;
        y1 = y0 + int'($urandom_range(0, 40)) - 20;
      end
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      needed = (dx > dy) ? dx : dy;
      roll = $urandom_range(9);
      if (roll == 0) nsteps = $urandom_range(0, needed);
      else if (roll < 3) nsteps = needed + $urandom_range(1, 3);
      else nsteps = needed;
    end
    h0 = $urandom;
    h1 = $urandom;
    roll = $urandom_range(9);
    if (roll < 4) begin
      h0 = int'(cfg_dark);
      h1 = int'(cfg_dark);
    end else if (roll == 4) begin
      h0 = int'(cfg_dark);
    end else if (roll == 5) begin
      h1 = int'(cfg_dark);
    end
    push_start(x0, y0, x1, y1, h0, h1);
    push_steps(nsteps);
    return n + nsteps + 1;
  endfunction

  task automatic set_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_BITS'(val);
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_FRAME_WIDTH:  cfg_w = val[DIM_BITS-1:0];
      CFG_FRAME_HEIGHT: cfg_h = val[DIM_BITS-1:0];
      CFG_LINE_STRIDE:  cfg_stride = val[STRIDE_BITS-1:0];
      CFG_BPP:          cfg_bpp = val[BPP_BITS-1:0];
      CFG_BYTE_ORDER:   cfg_order = val[0];
      CFG_DARK_LEVEL:   cfg_dark = val[HEIGHT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (req_queue.size() != 0 || in_bus.valid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin : feed
    line_req_t nx;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_beat) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nx = req_queue.pop_front();
        offered = nx;
        in_bus.req_type     <= nx.kind;
        in_bus.start_x      <= nx.sx;
        in_bus.start_y      <= nx.sy;
        in_bus.end_x        <= nx.ex;
        in_bus.end_y        <= nx.ey;
        in_bus.start_height <= nx.sh;
        in_bus.end_height   <= nx.eh;
        in_bus.valid        <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // pixel port ready, with an occasional long hold-off
  always @(negedge clk) begin : sink_side
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // accepted requests feed the predictor; pixel beats are checked in order
  always @(posedge clk) begin : watch
    pixel_wr_t got, want;
    in_beat = 1'b0;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        in_beat = 1'b1;
        expected_pixels.push_back(rasterize(offered));
      end
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.pixel_valid, out_bus.byte_address, out_bus.byte_first,
               out_bus.byte_second, out_bus.byte_third, out_bus.last_pixel};
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("%0t: unexpected pixel beat %s", $time, describe(got));
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: pixel mismatch\n  expected %s\n  actual   %s",
                       $time, describe(want), describe(got));
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int made;
    int w, h, s, b, o, d;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_START;
    in_bus.start_x = '0;
    in_bus.start_y = '0;
    in_bus.end_x = '0;
    in_bus.end_y = '0;
    in_bus.start_height = '0;
    in_bus.end_height = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_FRAME_WIDTH;
    cfg_bus.data = '0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    in_beat = 1'b0;
    cfg_w = RST_FRAME_WIDTH;
    cfg_h = RST_FRAME_HEIGHT;
    cfg_stride = RST_LINE_STRIDE;
    cfg_bpp = RST_BPP;
    cfg_order = ORDER_BGR;
    cfg_dark = '0;
    pos_x = 0; pos_y = 0; goal_x = 0; goal_y = 0;
    run_x = 0; run_y = 0; neg_x = 0; neg_y = 0;
    err_acc = 0; white = 0; drawing = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: step with no line, single point, short lines, extremes, frame edge
    push_steps(1);
    push_start(5, 5, 5, 5, 0, 0);
    push_steps(1);
    push_start(0, 0, 3, 1, 1, 0);
    push_steps(3);
    push_start(10, 10, 8, 15, 0, 0);
    push_steps(5);
    push_start(-32768, -32768, 32767, 32767, -32768, 32767);
    push_steps(2);
    push_start(1023, 767, 1025, 769, 0, 5);
    push_steps(2);
    push_start(32767, -1, -32768, 0, 32767, 32767);
    push_steps(1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: begin w = 4096; h = 4096; s = 16384; b = 24; o = ORDER_RGB; d = -32768; end
          2: begin w = 1; h = 1; s = 1; b = 32; o = ORDER_BGR; d = 32767; end
          3: begin w = 8191; h = 8191; s = 32767; b = 63; o = ORDER_RGB; d = $urandom; end
          4: begin w = 0; h = 0; s = 0; b = 0; o = ORDER_BGR; d = 0; end
          default: begin
            w = $urandom_range(1, 300);
            h = $urandom_range(1, 300);
            s = $urandom_range(1, 16384);
            b = ($urandom_range(1) == 0) ? ($urandom_range(1) ? 24 : 32) : $urandom_range(0, 63);
            o = $urandom_range(1);
            d = $urandom;
          end
        endcase
        set_reg(CFG_FRAME_WIDTH, w);
        set_reg(CFG_FRAME_HEIGHT, h);
        set_reg(CFG_LINE_STRIDE, s);
        set_reg(CFG_BPP, b);
        set_reg(CFG_BYTE_ORDER, o);
        set_reg(CFG_DARK_LEVEL, d);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      // long hold-off on the pixel port while requests keep coming
      if (p == 0 || p == 5) hold_req = HOLD_CYCLES;
      made = 0;
      while (made < PHASE_ITEMS) made += make_line();
      wait_idle();
    end

    repeat (12) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
